// File: sv/dpsd_pkg.sv
package dpsd_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int OUT_DATA_W  = 40;

    localparam logic [1:0] KIND_LITERAL = 2'd0;
    localparam logic [1:0] KIND_COPY    = 2'd1;
    localparam logic [1:0] KIND_TRUNC   = 2'd2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  literal_value;
        logic [15:0] copy_offset;
        logic [15:0] copy_length;
    } dpsd_item_t;

    typedef struct packed {
        logic       valid;
        dpsd_item_t item;
    } dpsd_push_t;

    typedef struct packed {
        logic       not_empty;
        dpsd_item_t item;
    } dpsd_head_t;

endpackage

// File: sv/dpsd_front.sv
module dpsd_front
    import dpsd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    input  logic       queue_full,
    output logic       in_ready,
    output dpsd_push_t push
);

    typedef enum logic [2:0] {
        PH_TYPE,
        PH_LEN_LO,
        PH_LEN_HI,
        PH_DATA,
        PH_OFF_LO,
        PH_OFF_HI
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic        is_copy_reg, is_copy_next;
    logic [15:0] length_reg, length_next;
    logic [15:0] left_reg, left_next;
    logic [7:0]  offset_low_reg, offset_low_next;
    logic [15:0] full_length;
    logic        emit;
    logic        was_data;
    dpsd_item_t  item;

    assign in_ready = !queue_full;

    always_comb
    begin
        phase_next      = phase_reg;
        is_copy_next    = is_copy_reg;
        length_next     = length_reg;
        left_next       = left_reg;
        offset_low_next = offset_low_reg;
        full_length     = {in_byte, length_reg[7:0]};
        emit            = 1'b0;
        was_data        = 1'b0;
        item            = '0;
        unique case (phase_reg)
            PH_LEN_LO:
            begin
                length_next = {8'h00, in_byte};
                phase_next  = PH_LEN_HI;
            end
            PH_LEN_HI:
            begin
                length_next = full_length;
                if (is_copy_reg)
                begin
                    phase_next = PH_OFF_LO;
                end
                else if (full_length == 16'd0)
                begin
                    phase_next = PH_TYPE;
                end
                else
                begin
                    left_next  = full_length;
                    phase_next = PH_DATA;
                end
            end
            PH_DATA:
            begin
                was_data           = 1'b1;
                emit               = 1'b1;
                item.kind          = KIND_LITERAL;
                item.literal_value = in_byte;
                left_next          = left_reg - 16'd1;
                if (left_next == 16'd0)
                begin
                    phase_next = PH_TYPE;
                end
            end
            PH_OFF_LO:
            begin
                offset_low_next = in_byte;
                phase_next      = PH_OFF_HI;
            end
            PH_OFF_HI:
            begin
                emit             = 1'b1;
                item.kind        = KIND_COPY;
                item.copy_offset = {in_byte, offset_low_reg};
                item.copy_length = length_reg;
                phase_next       = PH_TYPE;
            end
            default:
            begin
                is_copy_next    = (in_byte != 8'h00);
                length_next     = 16'd0;
                left_next       = 16'd0;
                offset_low_next = 8'h00;
                phase_next      = PH_LEN_LO;
            end
        endcase
        if (in_last)
        begin
            if (phase_next != PH_TYPE)
            begin
                emit               = 1'b1;
                item.kind          = KIND_TRUNC;
                item.literal_value = was_data ? in_byte : 8'h00;
                item.copy_offset   = 16'd0;
                item.copy_length   = 16'd0;
            end
            phase_next = PH_TYPE;
            left_next  = 16'd0;
        end
    end

    assign push.valid = in_valid && in_ready && emit;
    assign push.item  = item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_TYPE;
            is_copy_reg    <= 1'b0;
            length_reg     <= 16'd0;
            left_reg       <= 16'd0;
            offset_low_reg <= 8'h00;
        end
        else if (in_valid && in_ready)
        begin
            phase_reg      <= phase_next;
            is_copy_reg    <= is_copy_next;
            length_reg     <= length_next;
            left_reg       <= left_next;
            offset_low_reg <= offset_low_next;
        end
    end

endmodule

// File: sv/dpsd_queue.sv
module dpsd_queue
    import dpsd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  dpsd_push_t push,
    input  logic       pop,
    output logic       full,
    output dpsd_head_t head
);

    dpsd_item_t              entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [QUEUE_AW:0]       count_reg, count_next;
    logic                    do_push, do_pop;

    assign full           = (count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign head.not_empty = (count_reg != '0);
    assign head.item      = entry_reg[rd_ptr_reg];
    assign do_push        = push.valid && !full;
    assign do_pop         = pop && head.not_empty;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push.item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

// File: sv/dpsd_back.sv
module dpsd_back
    import dpsd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  dpsd_head_t            head,
    output logic                  pop,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [OUT_DATA_W-1:0] out_data,
    output logic [1:0]            out_user
);

    logic                  valid_reg;
    logic [OUT_DATA_W-1:0] data_reg;
    logic [1:0]            user_reg;

    assign pop       = head.not_empty && (!valid_reg || out_ready);
    assign out_valid = valid_reg;
    assign out_data  = data_reg;
    assign out_user  = user_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!valid_reg || out_ready)
        begin
            valid_reg <= head.not_empty;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            data_reg <= {head.item.copy_length, head.item.copy_offset,
                         head.item.literal_value};
            user_reg <= head.item.kind;
        end
    end

endmodule

// File: sv/delta_patch_stream_decoder_top.sv
// Add/copy delta patch decoder. Patch bytes arrive on the slave stream, one
// byte per transaction, with tlast marking the final byte of a patch. Each
// record is a type byte, a little-endian length and then either the literal
// bytes of an add or a little-endian old-image offset for a copy.
// The master stream carries one result per transaction: tuser gives the kind
// (literal, copy or truncated record) and tdata the literal, offset and length.
// A byte is taken in every cycle while the four-entry result queue has room,
// so throughput is one byte per cycle. A result is written into the queue as
// the byte that causes it is accepted, and reaches the master side from the
// queue through the output register.
// When the receiver stalls, results gather in the queue and the slave side
// keeps accepting bytes until the queue is full, then drops tready.
// Reset returns the parser to expecting a type byte and empties the queue and
// the output register.
module delta_patch_stream_decoder_top
    import dpsd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,  // patch_byte
    input  logic                  s_axis_tlast,  // end_of_patch
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,  // literal_value, copy_offset, copy_length
    output logic [1:0]            m_axis_tuser   // kind
);

    dpsd_push_t push;
    dpsd_head_t head;
    logic       queue_full;
    logic       pop;

    dpsd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_byte    (s_axis_tdata),
        .in_last    (s_axis_tlast),
        .queue_full (queue_full),
        .in_ready   (s_axis_tready),
        .push       (push)
    );

    dpsd_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .full  (queue_full),
        .head  (head)
    );

    dpsd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .pop       (pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_user  (m_axis_tuser)
    );

endmodule

// File: tb/sv/tb_delta_patch_stream_decoder_top.sv
`timescale 1ns / 1ps

module tb_delta_patch_stream_decoder_top;

    import dpsd_pkg::*;

    typedef enum logic [2:0] {
        WANT_TYPE   = 3'd0,
        WANT_LEN_LO = 3'd1,
        WANT_LEN_HI = 3'd2,
        IN_ADD_DATA = 3'd3,
        WANT_OFF_LO = 3'd4,
        WANT_OFF_HI = 3'd5
    } parse_step_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata;
    logic                  s_axis_tlast;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [1:0]            m_axis_tuser;

    parse_step_t  step_now      = WANT_TYPE;
    logic         rec_is_copy   = 1'b0;
    logic [15:0]  rec_length    = 16'd0;
    logic [15:0]  add_left      = 16'd0;
    logic [7:0]   off_low_byte  = 8'd0;

    dpsd_item_t   due_results[$];
    logic [7:0]   stream_bytes[$];

    int           mismatch_count  = 0;
    int           bytes_sent      = 0;
    int           tx_gap_max      = 8;
    int           rx_stall_max    = 8;
    int           rx_hold_request = 0;
    int           rx_hold_left    = 0;
    int           rx_stall_left   = 0;

    delta_patch_stream_decoder_top DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic void decode_patch_byte(input logic [7:0] b, input logic last);
        dpsd_item_t res;
        logic       emit;
        logic       was_data;
        res      = '0;
        emit     = 1'b0;
        was_data = 1'b0;
        case (step_now)
            WANT_LEN_LO:
            begin
                rec_length = {8'h00, b};
                step_now   = WANT_LEN_HI;
            end
            WANT_LEN_HI:
            begin
                rec_length[15:8] = b;
                if (rec_is_copy)
                    step_now = WANT_OFF_LO;
                else if (rec_length == 16'd0)
                    step_now = WANT_TYPE;
                else
                begin
                    add_left = rec_length;
                    step_now = IN_ADD_DATA;
                end
            end
            IN_ADD_DATA:
            begin
                was_data          = 1'b1;
                emit              = 1'b1;
                res.kind          = KIND_LITERAL;
                res.literal_value = b;
                add_left          = add_left - 16'd1;
                if (add_left == 16'd0)
                    step_now = WANT_TYPE;
            end
            WANT_OFF_LO:
            begin
                off_low_byte = b;
                step_now     = WANT_OFF_HI;
            end
            WANT_OFF_HI:
            begin
                emit            = 1'b1;
                res.kind        = KIND_COPY;
                res.copy_offset = {b, off_low_byte};
                res.copy_length = rec_length;
                step_now        = WANT_TYPE;
            end
            default:
            begin
                rec_is_copy  = (b != 8'd0);
                rec_length   = 16'd0;
                add_left     = 16'd0;
                off_low_byte = 8'd0;
                step_now     = WANT_LEN_LO;
            end
        endcase
        // A stream that stops inside a record yields a single truncation result.
        if (last)
        begin
            if (step_now != WANT_TYPE)
            begin
                emit              = 1'b1;
                res               = '0;
                res.kind          = KIND_TRUNC;
                res.literal_value = was_data ? b : 8'd0;
            end
            step_now = WANT_TYPE;
            add_left = 16'd0;
        end
        if (emit)
            due_results.push_back(res);
    endfunction

    task automatic report_mismatch(input string what, input logic [41:0] got,
                                   input logic [41:0] want);
        $display("mismatch at %0t ns: %s, got %h, want %h", $time, what, got, want);
        mismatch_count++;
    endtask

    task automatic check_decoded_result(input logic [1:0] kind_got,
                                        input logic [OUT_DATA_W-1:0] data_got);
        dpsd_item_t want;
        if (due_results.size() == 0)
            report_mismatch("result with nothing due", {kind_got, data_got}, '0);
        else
        begin
            want = due_results.pop_front();
            if (kind_got !== want.kind)
                report_mismatch("kind", 42'(kind_got), 42'(want.kind));
            if (data_got[7:0] !== want.literal_value)
                report_mismatch("literal_value", 42'(data_got[7:0]),
                                42'(want.literal_value));
            if (data_got[23:8] !== want.copy_offset)
                report_mismatch("copy_offset", 42'(data_got[23:8]),
                                42'(want.copy_offset));
            if (data_got[39:24] !== want.copy_length)
                report_mismatch("copy_length", 42'(data_got[39:24]),
                                42'(want.copy_length));
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1)
            check_decoded_result(m_axis_tuser, m_axis_tdata);
    end

    always @(posedge clk)
    begin
        if (rx_hold_request > 0)
        begin
            rx_hold_left    = rx_hold_request;
            rx_hold_request = 0;
        end
        if (rx_hold_left > 0)
        begin
            m_axis_tready <= 1'b0;
            rx_hold_left--;
        end
        else if (rx_stall_left > 0)
        begin
            m_axis_tready <= 1'b0;
            rx_stall_left--;
        end
        else if (m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1)
        begin
            rx_stall_left = $urandom_range(rx_stall_max, 0);
            if (rx_stall_left > 0)
            begin
                m_axis_tready <= 1'b0;
                rx_stall_left--;
            end
            else
                m_axis_tready <= 1'b1;
        end
        else
            m_axis_tready <= 1'b1;
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = $urandom_range(tx_gap_max, 0);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        @(posedge clk);
        while (s_axis_tready !== 1'b1)
            @(posedge clk);
        decode_patch_byte(b, last);
        bytes_sent++;
    endtask

    task automatic send_stream(input logic end_with_last);
        int i;
        for (i = 0; i < stream_bytes.size(); i++)
            send_byte(stream_bytes[i], end_with_last && (i == stream_bytes.size() - 1));
        stream_bytes.delete();
    endtask

    task automatic test_directed_records();
        tx_gap_max   = 8;
        rx_stall_max = 8;
        // Add of two bytes at the byte extremes, ending the stream cleanly.
        stream_bytes = '{8'h00, 8'h02, 8'h00, 8'h00, 8'hFF};
        send_stream(1'b1);
        // Empty add emits nothing.
        stream_bytes = '{8'h00, 8'h00, 8'h00};
        send_stream(1'b0);
        // Copy with every length and offset bit set.
        stream_bytes = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
        send_stream(1'b0);
        // Empty copy still emits a command; the stream ends cleanly after it.
        stream_bytes = '{8'h01, 8'h00, 8'h00, 8'h00, 8'h00};
        send_stream(1'b1);
        // Stream ends on a lone type byte.
        stream_bytes = '{8'h00};
        send_stream(1'b1);
        // Stream ends inside add data; the final byte rides on the truncation.
        stream_bytes = '{8'h00, 8'h02, 8'h00, 8'h7E};
        send_stream(1'b1);
        // Stream ends after the length of a copy.
        stream_bytes = '{8'h80, 8'h34, 8'h12};
        send_stream(1'b1);
    endtask

    task automatic test_output_backpressure();
        tx_gap_max      = 0;
        rx_stall_max    = 0;
        rx_hold_request = 80;
        stream_bytes = '{8'h00, 8'd48, 8'h00};
        repeat (48) stream_bytes.push_back(8'($urandom_range(255, 0)));
        send_stream(1'b1);
    endtask

    task automatic test_random_streams();
        int          sent_start;
        int          streams;
        int          pick;
        int          size_pick;
        int          cut;
        int          n;
        logic [15:0] rec_len;
        logic [15:0] rec_off;
        sent_start = bytes_sent;
        streams    = 0;
        while (bytes_sent - sent_start < 2000)
        begin
            if (streams % 12 == 0)
            begin
                tx_gap_max   = 8 * $urandom_range(1, 0);
                rx_stall_max = 8 * $urandom_range(1, 0);
            end
            streams++;
            pick = $urandom_range(99, 0);
            if (pick < 10)
            begin
                n = $urandom_range(12, 1);
                repeat (n) send_byte(8'($urandom_range(255, 0)), $urandom_range(7, 0) == 0);
            end
            else
            begin
                n = $urandom_range(5, 1);
                repeat (n)
                begin
                    if ($urandom_range(1, 0) == 0)
                    begin
                        size_pick = $urandom_range(99, 0);
                        if (size_pick < 85)
                            rec_len = 16'($urandom_range(8, 0));
                        else if (size_pick < 97)
                            rec_len = 16'($urandom_range(40, 9));
                        else
                            rec_len = 16'($urandom_range(300, 41));
                        stream_bytes.push_back(8'h00);
                        stream_bytes.push_back(rec_len[7:0]);
                        stream_bytes.push_back(rec_len[15:8]);
                        repeat (rec_len) stream_bytes.push_back(8'($urandom_range(255, 0)));
                    end
                    else
                    begin
                        rec_len = ($urandom_range(3, 0) == 0) ? 16'd0
                                                              : 16'($urandom_range(65535, 0));
                        rec_off = 16'($urandom_range(65535, 0));
                        stream_bytes.push_back(8'($urandom_range(255, 1)));
                        stream_bytes.push_back(rec_len[7:0]);
                        stream_bytes.push_back(rec_len[15:8]);
                        stream_bytes.push_back(rec_off[7:0]);
                        stream_bytes.push_back(rec_off[15:8]);
                    end
                end
                if (pick < 30)
                begin
                    cut = $urandom_range(stream_bytes.size() - 1, 1);
                    while (stream_bytes.size() > cut)
                        void'(stream_bytes.pop_back());
                    send_stream(1'b1);
                end
                else if (pick < 40)
                    send_stream(1'b0);
                else
                    send_stream(1'b1);
            end
        end
    endtask

    initial
    begin
        #20_000_000;
        $display("FAIL");
        $finish;
    end

    initial
    begin
        int drain_cycles;
        drain_cycles  = 0;
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= 8'd0;
        s_axis_tlast  <= 1'b0;
        m_axis_tready <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        test_directed_records();
        test_output_backpressure();
        test_random_streams();

        s_axis_tvalid <= 1'b0;
        while (due_results.size() != 0 && drain_cycles < 5000)
        begin
            @(posedge clk);
            drain_cycles++;
        end
        repeat (10) @(posedge clk);
        if (due_results.size() != 0)
            report_mismatch("results never delivered", 42'(due_results.size()), 42'(0));

        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
